// ----- src/stqf_pkg.sv -----
package stqf_pkg;

    // Input word: one load or render command
    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        index;
        logic [31:0]        texel;
        logic signed [15:0] corner_u;
        logic signed [15:0] corner_v;
        logic [7:0]         corner_shade;
    } t_in_word;

    // Output word: one shaded pixel
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  column;
        logic [23:0] color_out;
        logic        last;
    } t_out_word;

    // Pixel tag that travels alongside the texel read
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] column;
        logic       last;
        logic [7:0] shade;
    } t_pix_meta;

    // Command modes
    localparam logic [1:0] MODE_TEXEL  = 2'd0;
    localparam logic [1:0] MODE_CORNER = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // Corner slots
    localparam int         NUM_CORNERS = 4;
    localparam logic [1:0] CORNER_TL   = 2'd0;
    localparam logic [1:0] CORNER_TR   = 2'd1;
    localparam logic [1:0] CORNER_BL   = 2'd2;
    localparam logic [1:0] CORNER_BR   = 2'd3;

    // Interpolated channels
    localparam int         NUM_CH = 3;
    localparam logic [1:0] CH_U   = 2'd0;
    localparam logic [1:0] CH_V   = 2'd1;
    localparam logic [1:0] CH_S   = 2'd2;

    // 24.8 fixed point
    localparam int FRAC_BITS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_ROW,
        ST_SPAN,
        ST_FETCH,
        ST_COL
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_EDGE,
        ALU_SPAN
    } t_alu_op;

endpackage

// ----- src/stqf_alu.sv -----
module stqf_alu #(
    parameter int QUAD_SIDE = 8
) (
    input  stqf_pkg::t_alu_op i_op,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic [31:0]       o_y
);
    import stqf_pkg::*;

    localparam logic [31:0] StepMul = 32'(255 / QUAD_SIDE);

    logic [31:0] w_x;
    logic [31:0] w_z;
    logic        w_cin;
    logic [31:0] w_sum;
    logic [31:0] w_pre;
    logic [31:0] w_prod;

    // One adder: a + b, or b - a for the step ops
    always_comb begin
        if (i_op == ALU_ADD) begin
            w_x   = i_a;
            w_z   = i_b;
            w_cin = 1'b0;
        end else begin
            w_x   = i_b;
            w_z   = ~i_a;
            w_cin = 1'b1;
        end
    end

    assign w_sum = w_x + w_z + {31'd0, w_cin};

    // Edge steps scale the whole-texel delta up to 24.8 first
    assign w_pre  = (i_op == ALU_EDGE) ? {w_sum[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}} : w_sum;
    assign w_prod = w_pre * StepMul;

    // Floor shift right by the fraction width
    assign o_y = (i_op == ALU_ADD) ? w_sum
                                   : {{FRAC_BITS{w_prod[31]}}, w_prod[31:FRAC_BITS]};

endmodule

// ----- src/stqf_texmem.sv -----
module stqf_texmem #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    localparam int Depth = 2 ** ADDR_W;

    logic [31:0] r_mem [Depth];
    logic [31:0] r_rd_data;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/stqf_shade.sv -----
module stqf_shade (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  stqf_pkg::t_pix_meta i_meta,
    input  logic [31:0]         i_texel,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output stqf_pkg::t_out_word o_out_word
);
    import stqf_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_word r_word;
    t_out_word n_word;

    logic [15:0] w_b;
    logic [15:0] w_g;
    logic [15:0] w_r;

    // Per-byte shading; alpha is dropped
    assign w_b = 16'(i_texel[7:0])   * 16'(i_meta.shade);
    assign w_g = 16'(i_texel[15:8])  * 16'(i_meta.shade);
    assign w_r = 16'(i_texel[23:16]) * 16'(i_meta.shade);

    // Output register; the sequencer only loads it when it is free
    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (i_load) begin
            n_valid          = 1'b1;
            n_word.row       = i_meta.row;
            n_word.column    = i_meta.column;
            n_word.last      = i_meta.last;
            n_word.color_out = {w_r[15:8], w_g[15:8], w_b[15:8]};
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ----- src/shaded_texture_quad_fill.sv -----
// Texel and corner loads keep the block idle; it is ready again the next cycle.
// A render runs the edge, row, span, fetch and column steps; with no output stall,
// one shared add/step unit does one edge, row, span or column update per cycle.
// The first pixel is registered from the first texel read after the span steps; one pixel per fetch.
// Synchronous active-low reset clears the sequencer, the corner registers and output valid;
// the texture memory is not cleared and holds garbage until written.
module shaded_texture_quad_fill #(
    parameter int QUAD_SIDE     = 8,
    parameter int TEX_SIDE_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stqf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stqf_pkg::t_out_word o_out_word
);
    import stqf_pkg::*;

    localparam int             CntW    = $clog2(QUAD_SIDE);
    localparam logic [CntW-1:0] CntLast = CntW'(QUAD_SIDE - 1);
    localparam int             AddrW   = 2 * TEX_SIDE_BITS;
    localparam logic [1:0]     KLast   = 2'(NUM_CH - 1);

    // Sequencer state
    t_state          r_state, n_state;
    logic [1:0]      r_k, n_k;
    logic            r_side, n_side;
    logic [CntW-1:0] r_row, n_row;
    logic [CntW-1:0] r_col, n_col;
    logic            r_fetch_valid, n_fetch_valid;
    t_pix_meta       r_meta, n_meta;

    // Interpolator registers, indexed by channel u, v, shade
    logic [31:0] r_left  [NUM_CH];
    logic [31:0] n_left  [NUM_CH];
    logic [31:0] r_right [NUM_CH];
    logic [31:0] n_right [NUM_CH];
    logic [31:0] r_dl    [NUM_CH];
    logic [31:0] n_dl    [NUM_CH];
    logic [31:0] r_dr    [NUM_CH];
    logic [31:0] n_dr    [NUM_CH];
    logic [31:0] r_cur   [NUM_CH];
    logic [31:0] n_cur   [NUM_CH];
    logic [31:0] r_ds    [NUM_CH];
    logic [31:0] n_ds    [NUM_CH];

    // Corner registers
    logic [15:0] r_cu [NUM_CORNERS];
    logic [15:0] n_cu [NUM_CORNERS];
    logic [15:0] r_cv [NUM_CORNERS];
    logic [15:0] n_cv [NUM_CORNERS];
    logic [7:0]  r_cs [NUM_CORNERS];
    logic [7:0]  n_cs [NUM_CORNERS];

    // Corners widened to 32 bits per channel
    logic [31:0] w_tl [NUM_CH];
    logic [31:0] w_tr [NUM_CH];
    logic [31:0] w_bl [NUM_CH];
    logic [31:0] w_br [NUM_CH];

    t_alu_op     w_op;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_y;

    logic             w_accept;
    logic             w_wr_en;
    logic             w_rd_en;
    logic [AddrW-1:0] w_rd_addr;
    logic [31:0]      w_rd_data;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Sign-extend u and v, zero-extend shade
    always_comb begin
        w_tl[CH_U] = {{16{r_cu[CORNER_TL][15]}}, r_cu[CORNER_TL]};
        w_tr[CH_U] = {{16{r_cu[CORNER_TR][15]}}, r_cu[CORNER_TR]};
        w_bl[CH_U] = {{16{r_cu[CORNER_BL][15]}}, r_cu[CORNER_BL]};
        w_br[CH_U] = {{16{r_cu[CORNER_BR][15]}}, r_cu[CORNER_BR]};
        w_tl[CH_V] = {{16{r_cv[CORNER_TL][15]}}, r_cv[CORNER_TL]};
        w_tr[CH_V] = {{16{r_cv[CORNER_TR][15]}}, r_cv[CORNER_TR]};
        w_bl[CH_V] = {{16{r_cv[CORNER_BL][15]}}, r_cv[CORNER_BL]};
        w_br[CH_V] = {{16{r_cv[CORNER_BR][15]}}, r_cv[CORNER_BR]};
        w_tl[CH_S] = {24'd0, r_cs[CORNER_TL]};
        w_tr[CH_S] = {24'd0, r_cs[CORNER_TR]};
        w_bl[CH_S] = {24'd0, r_cs[CORNER_BL]};
        w_br[CH_S] = {24'd0, r_cs[CORNER_BR]};
    end

    // Texel address from the integer parts of v and u
    assign w_rd_addr = {r_cur[CH_V][FRAC_BITS +: TEX_SIDE_BITS],
                        r_cur[CH_U][FRAC_BITS +: TEX_SIDE_BITS]};

    // Sequencer: next state, shared-unit operands and register updates
    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_side        = r_side;
        n_row         = r_row;
        n_col         = r_col;
        n_fetch_valid = 1'b0;
        n_meta        = r_meta;
        n_left        = r_left;
        n_right       = r_right;
        n_dl          = r_dl;
        n_dr          = r_dr;
        n_cur         = r_cur;
        n_ds          = r_ds;
        n_cu          = r_cu;
        n_cv          = r_cv;
        n_cs          = r_cs;
        w_op          = ALU_ADD;
        w_a           = r_cur[r_k];
        w_b           = r_ds[r_k];
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.mode)
                        MODE_TEXEL: begin
                            w_wr_en = 1'b1;
                        end
                        MODE_CORNER: begin
                            // corner index beyond 3 is dropped
                            if (i_in_word.index[15:2] == 14'd0) begin
                                n_cu[i_in_word.index[1:0]] = i_in_word.corner_u;
                                n_cv[i_in_word.index[1:0]] = i_in_word.corner_v;
                                n_cs[i_in_word.index[1:0]] = i_in_word.corner_shade;
                            end
                        end
                        MODE_RENDER: begin
                            for (int ch = 0; ch < NUM_CH; ch++) begin
                                n_left[ch]  = {w_tl[ch][31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
                                n_right[ch] = {w_tr[ch][31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
                            end
                            n_k     = 2'd0;
                            n_side  = 1'b0;
                            n_row   = '0;
                            n_col   = '0;
                            n_state = ST_EDGE;
                        end
                        default: ;
                    endcase
                end
            end

            // Edge steps: left u, v, s then right u, v, s
            ST_EDGE: begin
                w_op = ALU_EDGE;
                w_a  = r_side ? w_tr[r_k] : w_tl[r_k];
                w_b  = r_side ? w_br[r_k] : w_bl[r_k];
                if (r_side) begin
                    n_dr[r_k] = w_y;
                end else begin
                    n_dl[r_k] = w_y;
                end
                if (r_k == KLast) begin
                    n_k    = 2'd0;
                    n_side = !r_side;
                    if (r_side) begin
                        n_state = ST_ROW;
                    end
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            // Both edges advance before each row
            ST_ROW: begin
                w_op = ALU_ADD;
                w_a  = r_side ? r_right[r_k] : r_left[r_k];
                w_b  = r_side ? r_dr[r_k] : r_dl[r_k];
                if (r_side) begin
                    n_right[r_k] = w_y;
                end else begin
                    n_left[r_k] = w_y;
                end
                if (r_k == KLast) begin
                    n_k    = 2'd0;
                    n_side = !r_side;
                    if (r_side) begin
                        n_state = ST_SPAN;
                    end
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            // Span steps, and the row starts at the left edge
            ST_SPAN: begin
                w_op       = ALU_SPAN;
                w_a        = r_left[r_k];
                w_b        = r_right[r_k];
                n_ds[r_k]  = w_y;
                n_cur[r_k] = r_left[r_k];
                if (r_k == KLast) begin
                    n_k     = 2'd0;
                    n_state = ST_FETCH;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            // Issue the texel read once the output register will be free
            ST_FETCH: begin
                if (!o_out_valid || !i_out_stall) begin
                    w_rd_en       = 1'b1;
                    n_fetch_valid = 1'b1;
                    n_meta.row    = 3'(r_row);
                    n_meta.column = 3'(r_col);
                    n_meta.last   = (r_row == CntLast) && (r_col == CntLast);
                    n_meta.shade  = r_cur[CH_S][FRAC_BITS +: 8];
                    if (r_col == CntLast) begin
                        n_col = '0;
                        if (r_row == CntLast) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_row   = r_row + CntW'(1);
                            n_state = ST_ROW;
                        end
                    end else begin
                        n_state = ST_COL;
                    end
                end
            end

            // Step u, v, s along the row
            ST_COL: begin
                w_op       = ALU_ADD;
                w_a        = r_cur[r_k];
                w_b        = r_ds[r_k];
                n_cur[r_k] = w_y;
                if (r_k == KLast) begin
                    n_k     = 2'd0;
                    n_col   = r_col + CntW'(1);
                    n_state = ST_FETCH;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_k           <= 2'd0;
            r_side        <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
            r_fetch_valid <= 1'b0;
            r_cu          <= '{default: '0};
            r_cv          <= '{default: '0};
            r_cs          <= '{default: '0};
        end else begin
            r_state       <= n_state;
            r_k           <= n_k;
            r_side        <= n_side;
            r_row         <= n_row;
            r_col         <= n_col;
            r_fetch_valid <= n_fetch_valid;
            r_cu          <= n_cu;
            r_cv          <= n_cv;
            r_cs          <= n_cs;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_meta  <= n_meta;
        r_left  <= n_left;
        r_right <= n_right;
        r_dl    <= n_dl;
        r_dr    <= n_dr;
        r_cur   <= n_cur;
        r_ds    <= n_ds;
    end

    stqf_alu #(
        .QUAD_SIDE (QUAD_SIDE)
    ) u_alu (
        .i_op (w_op),
        .i_a  (w_a),
        .i_b  (w_b),
        .o_y  (w_y)
    );

    stqf_texmem #(
        .ADDR_W (AddrW)
    ) u_texmem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_in_word.index[AddrW-1:0]),
        .i_wr_data (i_in_word.texel),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    stqf_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_fetch_valid),
        .i_meta      (r_meta),
        .i_texel     (w_rd_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // A texel landing must never overwrite a pixel that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_valid |-> (!o_out_valid || !i_out_stall))
        else $error("pixel landed on a stalled output word");

    // Reads are only issued from the fetch step
    a_fetch_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_valid |-> ($past(r_state) == ST_FETCH))
        else $error("texel read outside fetch step");

    // A render word starts the edge setup
    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.mode == MODE_RENDER)) |=> (r_state == ST_EDGE))
        else $error("render word did not start edge setup");

endmodule
